[hw/rtl/lba_pkg.sv]
// Package: sizes, entry layout and controller states of the lease block allocator.
`timescale 1ns / 1ps
package lba_pkg;
  localparam int NUM_BLOCKS  = 1024;
  localparam int IDX_W       = $clog2(NUM_BLOCKS);
  localparam int TIME_BITS   = 32;
  localparam int BLK_W       = 11;
  localparam int LEASE_W     = 16;
  localparam logic [LEASE_W-1:0] LEASE_RESET = 16'd600;
  localparam logic [IDX_W-1:0]   LAST_IDX    = IDX_W'(NUM_BLOCKS - 1);

  typedef enum logic [0:0] {
    OP_ALLOC  = 1'b0,
    OP_ACCESS = 1'b1
  } op_t;

  typedef struct packed {
    logic                 free;
    logic [TIME_BITS-1:0] lease_end;
  } entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN
  } state_t;
endpackage

[hw/rtl/lease_block_allocator.sv]
// Top level: lease block allocator over one block-state memory with a per-request scan.
`timescale 1ns / 1ps
// Sweep: each request runs one read-modify-write sweep of the block-state memory, one
//   entry a cycle through ST_SCAN and ST_DRAIN; ST_FIN then loads the output register.
// Requests: one at a time; ST_FIN waits until the output register is free, and the next
//   request is taken while a finished result still waits in the output register.
// Reset: synchronous, active low; a clearing pass over the memory then marks every
//   block free, with in_ready low; configuration writes are taken throughout.
module lease_block_allocator import lba_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [LEASE_W-1:0]   cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_opcode,
  input  logic [TIME_BITS-1:0] in_request_time,
  input  logic [BLK_W-1:0]     in_block_number,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [BLK_W-1:0]     out_granted_block,
  output logic                 out_access_ok,
  output logic                 out_pool_empty
);

  // Block-state memory: free flag and lease end per block.
  entry_t mem [NUM_BLOCKS];

  state_t state_r, state_nxt;

  logic [LEASE_W-1:0]   lease_r;
  logic [IDX_W-1:0]     idx_r;       // read address during scan, write address during clear
  logic                 p_vld_r;     // read data valid for p_idx_r
  logic [IDX_W-1:0]     p_idx_r;
  entry_t               rd_data_r;

  // Request held for the whole sweep.
  logic                 op_r;
  logic [TIME_BITS-1:0] now_r;
  logic [IDX_W-1:0]     k_r;
  logic                 k_ok_r;      // block number in range

  // Sweep results.
  logic                 found_r;
  logic [IDX_W-1:0]     sel_r;
  logic                 held_k_r;
  logic [TIME_BITS-1:0] end_k_r;

  logic                 out_valid_r;
  logic [BLK_W-1:0]     granted_r;
  logic                 ok_r;
  logic                 empty_r;

  // Control decoded from the state.
  logic                 rd_en;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  entry_t               wr_data;
  logic                 out_free;
  logic                 fin_go;

  // Expiry applied to the entry coming back from the memory.
  logic                 free_new;
  // Lease end for a grant or renewal, saturating at the largest time.
  logic [TIME_BITS:0]   sum;
  logic [TIME_BITS-1:0] until_t;
  logic                 acc_ok;

  assign free_new = rd_data_r.free || (rd_data_r.lease_end <= now_r);
  assign sum      = {1'b0, now_r} + {{(TIME_BITS+1-LEASE_W){1'b0}}, lease_r};
  assign until_t  = sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
  assign acc_ok   = k_ok_r && held_k_r && (now_r < end_k_r);
  assign out_free = !out_valid_r || out_ready;
  assign fin_go   = (state_r == ST_FIN) && out_free;

  assign cfg_ready         = 1'b1;
  assign in_ready          = (state_r == ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_granted_block = granted_r;
  assign out_access_ok     = ok_r;
  assign out_pool_empty    = empty_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (idx_r == LAST_IDX) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_valid) state_nxt = ST_SCAN;
      ST_SCAN:  if (idx_r == LAST_IDX) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_FIN;
      ST_FIN:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // Memory port control: clear writes, scan write-back, final grant or renewal.
  always_comb begin
    rd_en   = (state_r == ST_SCAN);
    wr_en   = 1'b0;
    wr_addr = p_idx_r;
    wr_data = '{free: free_new, lease_end: rd_data_r.lease_end};
    case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = idx_r;
        wr_data = '{free: 1'b1, lease_end: '0};
      end
      ST_SCAN, ST_DRAIN: begin
        wr_en = p_vld_r;
      end
      ST_FIN: begin
        wr_data = '{free: 1'b0, lease_end: until_t};
        if (op_r == OP_ALLOC) begin
          wr_en   = fin_go && found_r;
          wr_addr = sel_r;
        end else begin
          wr_en   = fin_go && acc_ok;
          wr_addr = k_r;
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[idx_r];
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      lease_r     <= LEASE_RESET;
      idx_r       <= '0;
      p_vld_r     <= 1'b0;
      found_r     <= 1'b0;
      held_k_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) lease_r <= cfg_data;
      // Drop the result once taken, unless a new one loads in the same cycle.
      if (out_valid_r && out_ready && !fin_go) out_valid_r <= 1'b0;

      p_vld_r <= rd_en;
      p_idx_r <= idx_r;

      case (state_r)
        ST_CLEAR: idx_r <= idx_r + 1'b1;
        ST_IDLE: begin
          idx_r <= '0;
          if (in_valid) begin
            // Hold the request and reset the sweep results.
            op_r     <= in_opcode;
            now_r    <= in_request_time;
            k_r      <= IDX_W'(in_block_number - 1'b1);
            k_ok_r   <= (in_block_number != '0) &&
                        ({1'b0, in_block_number} <= (BLK_W+1)'(NUM_BLOCKS));
            found_r  <= 1'b0;
            held_k_r <= 1'b0;
          end
        end
        ST_SCAN: idx_r <= idx_r + 1'b1;
        ST_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            if (op_r == OP_ALLOC) begin
              granted_r <= found_r ? BLK_W'({1'b0, sel_r} + 1'b1) : '0;
              ok_r      <= 1'b0;
              empty_r   <= !found_r;
            end else begin
              granted_r <= '0;
              ok_r      <= acc_ok;
              empty_r   <= 1'b0;
            end
          end
        end
        default: begin
        end
      endcase

      // Track the lowest free block and the accessed block's state after expiry.
      if (p_vld_r && (state_r == ST_SCAN || state_r == ST_DRAIN)) begin
        if (free_new && !found_r) begin
          found_r <= 1'b1;
          sel_r   <= p_idx_r;
        end
        if (p_idx_r == k_r) begin
          held_k_r <= !free_new;
          end_k_r  <= rd_data_r.lease_end;
        end
      end
    end
  end

endmodule

[test/lease_block_allocator_test.sv]
// Testbench: lease block allocator checked against a scoreboard of predicted lease results.
`timescale 1ns / 1ps
module lease_block_allocator_test;
  import lba_pkg::*;

  localparam int PEND_DEPTH = 16;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [LEASE_W-1:0]   cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_opcode = 1'b0;
  logic [TIME_BITS-1:0] in_request_time = '0;
  logic [BLK_W-1:0]     in_block_number = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [BLK_W-1:0]     out_granted_block;
  logic                 out_access_ok;
  logic                 out_pool_empty;

  lease_block_allocator dut (.*);

  always #5 clk = ~clk;

  // One predicted lease result per request transaction.
  typedef struct packed {
    logic [BLK_W-1:0] granted;
    logic             ok;
    logic             empty;
  } lease_result_t;

  lease_result_t        pending_results[PEND_DEPTH];
  int                   pend_wr = 0;
  int                   pend_rd = 0;
  logic [TIME_BITS-1:0] model_end[NUM_BLOCKS];
  logic                 model_free[NUM_BLOCKS];
  logic [LEASE_W-1:0]   model_lease;
  logic [TIME_BITS-1:0] clock_now;   // time for random traffic, mostly rising, with rare random jumps
  int                   mismatches = 0;
  int                   errors = 0;
  int                   burst_left = 0;

  function automatic logic [TIME_BITS-1:0] lease_until(logic [TIME_BITS-1:0] now);
    logic [TIME_BITS:0] sum;
    sum = {1'b0, now} + (TIME_BITS+1)'(model_lease);
    return sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
  endfunction

  // Expire, then allocate the lowest free block or renew a running lease.
  function automatic lease_result_t predict_lease(op_t op, logic [TIME_BITS-1:0] now,
                                                 logic [BLK_W-1:0] blk);
    lease_result_t r;
    int            k;
    r = '0;
    for (int i = 0; i < NUM_BLOCKS; i++)
      if (!model_free[i] && model_end[i] <= now) model_free[i] = 1'b1;
    if (op == OP_ALLOC) begin
      r.empty = 1'b1;
      for (int i = 0; i < NUM_BLOCKS; i++) begin
        if (model_free[i]) begin
          model_free[i] = 1'b0;
          model_end[i]  = lease_until(now);
          r.granted     = BLK_W'(i + 1);
          r.empty       = 1'b0;
          break;
        end
      end
    end else if (int'(blk) >= 1 && int'(blk) <= NUM_BLOCKS) begin
      k = int'(blk) - 1;
      if (!model_free[k] && now < model_end[k]) begin
        model_end[k] = lease_until(now);
        r.ok = 1'b1;
      end
    end
    return r;
  endfunction

  // Send one request: gaps between random-length bursts, valid held until taken.
  task automatic send_request(op_t op, logic [TIME_BITS-1:0] now, logic [BLK_W-1:0] blk);
    @(posedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    burst_left--;
    pending_results[pend_wr % PEND_DEPTH] = predict_lease(op, now, blk);
    pend_wr++;
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_request_time <= now;
    in_block_number <= blk;
    do @(posedge clk); while (!in_ready);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pend_wr != pend_rd) @(posedge clk);
    repeat (NUM_BLOCKS + 10) @(posedge clk);
  endtask

  // Write the lease length while idle; the predictor follows.
  task automatic write_lease(logic [LEASE_W-1:0] len);
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    model_lease  = len;
  endtask

  // Receiver stalls on its own pattern: calm stretches, then choppy ones.
  always @(posedge clk) begin
    if (($urandom_range(0, 255) & 8'h40) != 0) out_ready <= ($urandom_range(0, 3) != 0);
    else out_ready <= ($urandom_range(0, 9) != 0) || out_ready;
  end

  // Check each result transaction against the oldest prediction.
  always @(posedge clk) begin
    lease_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pend_wr == pend_rd) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected result granted=%0d", out_granted_block);
      end else begin
        want = pending_results[pend_rd % PEND_DEPTH];
        pend_rd++;
        if (want !== {out_granted_block, out_access_ok, out_pool_empty}) begin
          errors++;
          if (mismatches++ < 10)
            $display("mismatch: exp granted=%0d ok=%b empty=%b got granted=%0d ok=%b empty=%b",
                     want.granted, want.ok, want.empty,
                     out_granted_block, out_access_ok, out_pool_empty);
        end
      end
    end
  end

  // Cover field extremes, bad block numbers, saturation and backward time.
  task automatic test_directed();
    write_lease(16'd600);
    send_request(OP_ALLOC, 32'd0, 11'd0);
    send_request(OP_ALLOC, 32'd0, 11'h7FF);
    send_request(OP_ACCESS, 32'd10, 11'd1);
    send_request(OP_ACCESS, 32'd10, 11'd0);
    send_request(OP_ACCESS, 32'd10, 11'd1024);
    send_request(OP_ACCESS, 32'd10, 11'd1025);
    send_request(OP_ACCESS, 32'd10, 11'h7FF);
    send_request(OP_ACCESS, 32'd700, 11'd2);   // lease ran out
    send_request(OP_ACCESS, 32'd5, 11'd1);     // time goes backwards
    send_request(OP_ALLOC, 32'hFFFF_FF00, 11'd0);
    send_request(OP_ACCESS, 32'hFFFF_FFFE, 11'd1);
    send_request(OP_ACCESS, 32'hFFFF_FFFF, 11'd1);
    wait_drained();
    write_lease(16'd0);                        // zero lease: freed at next request
    send_request(OP_ALLOC, 32'd100, 11'd0);
    send_request(OP_ACCESS, 32'd100, 11'd1);
    send_request(OP_ALLOC, 32'd100, 11'd0);
    wait_drained();
  endtask

  // Mostly allocate/renew of recently granted blocks with random lease lengths.
  task automatic test_random(int count);
    logic [BLK_W-1:0] blk;
    clock_now = 32'd80000;
    for (int p = 0; p < 5; p++) begin
      write_lease(p == 0 ? 16'd1 : LEASE_W'($urandom_range(1, 3000)));
      for (int n = 0; n < count / 5; n++) begin
        clock_now += $urandom_range(0, 400);
        if ($urandom_range(0, 19) == 0) blk = BLK_W'($urandom);
        else blk = BLK_W'($urandom_range(1, 24));
        if ($urandom_range(0, 99) == 0) clock_now = $urandom | 32'h8000_0000;
        send_request(op_t'($urandom_range(0, 1)), clock_now, blk);
      end
      wait_drained();
    end
  endtask

  initial begin
    model_lease = LEASE_RESET;
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      model_end[i]  = '0;
      model_free[i] = 1'b1;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(535);
    if (errors == 0 && pend_wr == pend_rd) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // Each request costs a full sweep of the block-state memory, plus stalls and drains.
  initial begin
    #(40_000_000);
    $display("TB_ERROR");
    $finish;
  end
endmodule
